// ----- rtl/ll1p_pkg.sv -----
package ll1p_pkg;

	// Default sizes of the parser.
	localparam int STACK_DEPTH_DEF    = 64;
	localparam int MAX_RHS_DEF        = 8;
	localparam int MAX_EXPANSIONS_DEF = 31;

	// The table has one entry for each upper-case nonterminal and lookahead byte.
	localparam int NONTERMINALS = 26;
	localparam int TBL_DEPTH    = NONTERMINALS * 256;
	localparam int TBL_AW       = $clog2(TBL_DEPTH);

	// Fixed characters of the grammar.
	localparam logic [7:0] END_MARK    = 8'd35;
	localparam logic [7:0] EMPTY_MARK  = 8'd64;
	localparam logic [7:0] NT_LOW      = 8'd65;
	localparam logic [7:0] NT_HIGH     = 8'd90;
	localparam logic [6:0] START_RESET = 7'd83;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_BEGIN = 2'd2,
		REQ_INPUT = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		EV_APPLIED  = 2'd0,
		EV_ACCEPTED = 2'd1,
		EV_REJECTED = 2'd2
	} ev_code_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BEGIN,
		ST_RDTOP,
		ST_EVAL,
		ST_LOOKUP,
		ST_PUSH,
		ST_FLUSH,
		ST_FINAL
	} state_t;

	// One parse-table word: valid flag, clamped length and masked right-hand side.
	typedef struct packed {
		logic        valid;
		logic [3:0]  len;
		logic [63:0] rhs;
	} tbl_word_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  expanded_symbol;
		logic [7:0]  lookahead_symbol;
		logic [63:0] applied_rhs;
		logic [3:0]  applied_length;
		logic        last;
	} result_t;

endpackage

// ----- rtl/ll1p_req_if.sv -----
interface ll1p_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  entry_nonterminal;
	logic [7:0]  entry_lookahead;
	logic [63:0] rhs_symbols;
	logic [3:0]  rhs_length;
	logic [7:0]  input_symbol;

	modport source (output valid, req_type, entry_nonterminal, entry_lookahead, rhs_symbols,
		rhs_length, input_symbol, input ready);
	modport sink (input valid, req_type, entry_nonterminal, entry_lookahead, rhs_symbols,
		rhs_length, input_symbol, output ready);
endinterface

// ----- rtl/ll1p_res_if.sv -----
interface ll1p_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  expanded_symbol;
	logic [7:0]  lookahead_symbol;
	logic [63:0] applied_rhs;
	logic [3:0]  applied_length;
	logic        last;

	modport source (output valid, event_res, expanded_symbol, lookahead_symbol, applied_rhs,
		applied_length, last, input ready);
	modport sink (input valid, event_res, expanded_symbol, lookahead_symbol, applied_rhs,
		applied_length, last, output ready);
endinterface

// ----- rtl/ll1p_ram.sv -----
module ll1p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/ll1_table_driven_parser.sv -----
// An input symbol is read from the stack top and evaluated; each expansion is looked up in the
// table and its n symbols pushed, and results leave through the held and output registers.
// One item at a time: the stack memory port (one symbol push per cycle) and the registered
// reads of stack top and table set the pace of each expansion.
// Reset and the clear request both start a sweep over the 6656 table entries, one a cycle,
// during which no item is accepted; the parser is idle once the sweep is done.
module ll1_table_driven_parser #(
	parameter int STACK_DEPTH    = ll1p_pkg::STACK_DEPTH_DEF,
	parameter int MAX_RHS        = ll1p_pkg::MAX_RHS_DEF,
	parameter int MAX_EXPANSIONS = ll1p_pkg::MAX_EXPANSIONS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ll1p_req_if.sink   req,
	ll1p_res_if.source res,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);

	localparam int SIW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int EW  = $clog2(MAX_EXPANSIONS + 1);
	localparam int TW  = ll1p_pkg::TBL_AW;

	ll1p_pkg::state_t    state_q, state_d;
	logic [TW-1:0]       clr_q, clr_d;
	logic [SPW-1:0]      sp_q, sp_d;
	logic [EW-1:0]       exp_q, exp_d;
	logic                act_q, act_d;
	logic                pend_v_q, pend_v_d;
	logic                out_v_q, out_v_d;
	logic                fin_has_q, fin_has_d;
	logic [6:0]          start_q;
	logic [7:0]          la_q, la_d;
	logic [7:0]          top_q, top_d;
	logic [63:0]         rhs_q, rhs_d;
	logic [3:0]          cnt_q, cnt_d;
	logic [1:0]          fin_ev_q, fin_ev_d;
	ll1p_pkg::result_t   pend_q, pend_d;
	ll1p_pkg::result_t   out_q, out_d;

	logic                acc;
	logic                out_free;
	logic [3:0]          ld_len;
	logic [63:0]         ld_rhs;
	logic                ld_nt_ok;
	logic [7:0]          top_x;
	logic [SPW:0]        need;

	logic                tbl_we;
	logic [TW-1:0]       tbl_waddr, tbl_raddr;
	ll1p_pkg::tbl_word_t tbl_wdata, tbl_rdata;
	logic                stk_we;
	logic [SIW-1:0]      stk_waddr, stk_raddr;
	logic [7:0]          stk_wdata, stk_rdata;

	// Parse table and symbol stack.
	ll1p_ram #(.WIDTH($bits(ll1p_pkg::tbl_word_t)), .DEPTH(ll1p_pkg::TBL_DEPTH)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	ll1p_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign req.ready = (state_q == ll1p_pkg::ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !out_v_q || res.ready;

	// Result port is driven straight from the output register.
	assign res.valid            = out_v_q;
	assign res.event_res        = out_q.event_res;
	assign res.expanded_symbol  = out_q.expanded_symbol;
	assign res.lookahead_symbol = out_q.lookahead_symbol;
	assign res.applied_rhs      = out_q.applied_rhs;
	assign res.applied_length   = out_q.applied_length;
	assign res.last             = out_q.last;

	// Table entry preparation: clamp the length, zero unused bytes, fold a lone '@' to empty.
	always_comb begin
		ld_len = (req.rhs_length > 4'(MAX_RHS)) ? 4'(MAX_RHS) : req.rhs_length;
		for (int i = 0; i < 8; i++) begin
			ld_rhs[8*i +: 8] = (4'(i) < ld_len) ? req.rhs_symbols[8*i +: 8] : 8'h00;
		end
		if (ld_len == 4'd1 && ld_rhs == {56'h0, ll1p_pkg::EMPTY_MARK}) begin
			ld_len = 4'd0;
			ld_rhs = 64'h0;
		end
		ld_nt_ok = (req.entry_nonterminal >= ll1p_pkg::NT_LOW)
			&& (req.entry_nonterminal <= ll1p_pkg::NT_HIGH);
	end

	// Stack top as seen in the evaluate state; an empty stack reads as the bottom marker.
	assign top_x     = (sp_q == '0) ? ll1p_pkg::END_MARK : stk_rdata;
	assign stk_raddr = SIW'(sp_q - SPW'(1));
	assign tbl_raddr = (state_q == ll1p_pkg::ST_EVAL)
		? {5'(top_x - ll1p_pkg::NT_LOW), la_q}
		: {5'(top_q - ll1p_pkg::NT_LOW), la_q};
	assign need      = (SPW+1)'(sp_q) - (SPW+1)'(1) + (SPW+1)'(tbl_rdata.len);

	// Sequencer: next state, memory writes and result handling.
	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		sp_d      = sp_q;
		exp_d     = exp_q;
		act_d     = act_q;
		pend_v_d  = pend_v_q;
		fin_has_d = fin_has_q;
		la_d      = la_q;
		top_d     = top_q;
		rhs_d     = rhs_q;
		cnt_d     = cnt_q;
		fin_ev_d  = fin_ev_q;
		pend_d    = pend_q;
		out_d     = out_q;
		out_v_d   = out_v_q && !res.ready;
		tbl_we    = 1'b0;
		tbl_waddr = clr_q;
		tbl_wdata = '0;
		stk_we    = 1'b0;
		stk_waddr = sp_q[SIW-1:0];
		// Byte select kept at three bits so that a count of eight picks the top byte.
		stk_wdata = rhs_q[{cnt_q[2:0] - 3'd1, 3'b000} +: 8];

		unique case (state_q)
			ll1p_pkg::ST_CLEAR: begin
				tbl_we = 1'b1;
				clr_d  = clr_q + TW'(1);
				if (clr_q == TW'(ll1p_pkg::TBL_DEPTH - 1)) begin
					state_d = ll1p_pkg::ST_IDLE;
				end
			end
			ll1p_pkg::ST_IDLE: begin
				if (acc) begin
					la_d  = req.input_symbol;
					exp_d = '0;
					unique case (ll1p_pkg::req_code_t'(req.req_type))
						ll1p_pkg::REQ_LOAD: begin
							tbl_we    = ld_nt_ok;
							tbl_waddr = {5'(req.entry_nonterminal - ll1p_pkg::NT_LOW),
								req.entry_lookahead};
							tbl_wdata = '{valid: 1'b1, len: ld_len, rhs: ld_rhs};
						end
						ll1p_pkg::REQ_CLEAR: begin
							clr_d   = '0;
							state_d = ll1p_pkg::ST_CLEAR;
						end
						ll1p_pkg::REQ_BEGIN: begin
							stk_we    = 1'b1;
							stk_waddr = '0;
							stk_wdata = ll1p_pkg::END_MARK;
							state_d   = ll1p_pkg::ST_BEGIN;
						end
						ll1p_pkg::REQ_INPUT: begin
							if (act_q) begin
								state_d = ll1p_pkg::ST_RDTOP;
							end
						end
						default: ;
					endcase
				end
			end
			ll1p_pkg::ST_BEGIN: begin
				stk_we    = 1'b1;
				stk_waddr = SIW'(1);
				stk_wdata = {1'b0, start_q};
				sp_d      = SPW'(2);
				act_d     = 1'b1;
				state_d   = ll1p_pkg::ST_IDLE;
			end
			ll1p_pkg::ST_RDTOP: begin
				state_d = ll1p_pkg::ST_EVAL;
			end
			ll1p_pkg::ST_EVAL: begin
				top_d = top_x;
				priority if (top_x == ll1p_pkg::END_MARK) begin
					fin_ev_d  = (la_q == ll1p_pkg::END_MARK) ? ll1p_pkg::EV_ACCEPTED
						: ll1p_pkg::EV_REJECTED;
					fin_has_d = 1'b1;
					act_d     = 1'b0;
					state_d   = ll1p_pkg::ST_FLUSH;
				end else if (top_x == la_q) begin
					sp_d      = sp_q - SPW'(1);
					fin_has_d = 1'b0;
					state_d   = ll1p_pkg::ST_FLUSH;
				end else if (top_x < ll1p_pkg::NT_LOW || top_x > ll1p_pkg::NT_HIGH) begin
					fin_ev_d  = ll1p_pkg::EV_REJECTED;
					fin_has_d = 1'b1;
					act_d     = 1'b0;
					state_d   = ll1p_pkg::ST_FLUSH;
				end else begin
					state_d = ll1p_pkg::ST_LOOKUP;
				end
			end
			ll1p_pkg::ST_LOOKUP: begin
				priority if (!tbl_rdata.valid || exp_q >= EW'(MAX_EXPANSIONS)
						|| need > (SPW+1)'(STACK_DEPTH)) begin
					fin_ev_d  = ll1p_pkg::EV_REJECTED;
					fin_has_d = 1'b1;
					act_d     = 1'b0;
					state_d   = ll1p_pkg::ST_FLUSH;
				end else if (!pend_v_q || out_free) begin
					// The previous production moves to the output, this one waits.
					if (pend_v_q) begin
						out_d   = pend_q;
						out_v_d = 1'b1;
					end
					pend_v_d = 1'b1;
					pend_d   = '{event_res: ll1p_pkg::EV_APPLIED, expanded_symbol: top_q,
						lookahead_symbol: la_q, applied_rhs: tbl_rdata.rhs,
						applied_length: tbl_rdata.len, last: 1'b0};
					sp_d     = sp_q - SPW'(1);
					exp_d    = exp_q + EW'(1);
					rhs_d    = tbl_rdata.rhs;
					cnt_d    = tbl_rdata.len;
					state_d  = (tbl_rdata.len == 4'd0) ? ll1p_pkg::ST_RDTOP : ll1p_pkg::ST_PUSH;
				end
			end
			ll1p_pkg::ST_PUSH: begin
				// Push from the last symbol down so that the first ends on top.
				stk_we = 1'b1;
				sp_d   = sp_q + SPW'(1);
				cnt_d  = cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					state_d = ll1p_pkg::ST_RDTOP;
				end
			end
			ll1p_pkg::ST_FLUSH: begin
				priority if (!pend_v_q) begin
					state_d = fin_has_q ? ll1p_pkg::ST_FINAL : ll1p_pkg::ST_IDLE;
				end else if (out_free) begin
					out_d      = pend_q;
					out_d.last = !fin_has_q;
					out_v_d    = 1'b1;
					pend_v_d   = 1'b0;
					state_d    = fin_has_q ? ll1p_pkg::ST_FINAL : ll1p_pkg::ST_IDLE;
				end
			end
			ll1p_pkg::ST_FINAL: begin
				if (out_free) begin
					out_d   = '{event_res: fin_ev_q, expanded_symbol: 8'h00,
						lookahead_symbol: la_q, applied_rhs: 64'h0,
						applied_length: 4'd0, last: 1'b1};
					out_v_d = 1'b1;
					state_d = ll1p_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ll1p_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ll1p_pkg::ST_CLEAR;
			clr_q     <= '0;
			sp_q      <= '0;
			exp_q     <= '0;
			act_q     <= 1'b0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			fin_has_q <= 1'b0;
			start_q   <= ll1p_pkg::START_RESET;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			sp_q      <= sp_d;
			exp_q     <= exp_d;
			act_q     <= act_d;
			pend_v_q  <= pend_v_d;
			out_v_q   <= out_v_d;
			fin_has_q <= fin_has_d;
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		la_q     <= la_d;
		top_q    <= top_d;
		rhs_q    <= rhs_d;
		cnt_q    <= cnt_d;
		fin_ev_q <= fin_ev_d;
		pend_q   <= pend_d;
		out_q    <= out_d;
	end

	// The stack pointer never passes the stack depth.
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// No held production survives into the idle state.
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ll1p_pkg::ST_IDLE) |-> !pend_v_q)
		else $error("held result left behind at idle");

	// A push always has a symbol left to write.
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ll1p_pkg::ST_PUSH) |-> (cnt_q != 4'd0) && (sp_q < SPW'(STACK_DEPTH)))
		else $error("push with no symbol or no room");

	// A finished parse leaves the parser inactive.
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ll1p_pkg::ST_FINAL) |-> !act_q)
		else $error("parse still active after its verdict");

endmodule

// ----- tb/sv/ll1p_tb_if.sv -----
`timescale 1ns / 1ps

// Testbench-side copy of the request and result channels is not needed; the RTL
// interfaces are used directly. This file holds the stimulus item and pending action types.
package ll1p_tb_pkg;

	// One request item as the sender holds it.
	typedef struct packed {
		ll1p_pkg::req_code_t req_type;
		logic [7:0]          entry_nonterminal;
		logic [7:0]          entry_lookahead;
		logic [63:0]         rhs_symbols;
		logic [3:0]          rhs_length;
		logic [7:0]          input_symbol;
	} req_item_t;

	// A pending item may instead be a pause until all results are in, or a start-symbol write.
	typedef enum logic [1:0] {
		ACT_ITEM,
		ACT_DRAIN,
		ACT_START_WR
	} action_t;

	typedef struct packed {
		action_t    act;
		logic [6:0] start_value;
		req_item_t  item;
	} pending_t;
endpackage

// ----- tb/sv/ll1_table_driven_parser_test.sv -----
`timescale 1ns / 1ps

module ll1_table_driven_parser_test;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_wdata;

	ll1p_req_if req_ch ();
	ll1p_res_if res_ch ();

	ll1_table_driven_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.res(res_ch.source),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state.
	bit          tbl_valid [ll1p_pkg::TBL_DEPTH];
	logic [63:0] tbl_rhs [ll1p_pkg::TBL_DEPTH];
	logic [3:0]  tbl_len [ll1p_pkg::TBL_DEPTH];
	logic [7:0]  sym_stack [ll1p_pkg::STACK_DEPTH_DEF];
	int          sym_sp;
	bit          parsing;
	logic [6:0]  start_sym;

	ll1p_tb_pkg::pending_t pending_q[$];
	ll1p_pkg::result_t     expected_q[$];
	int       mismatches;
	int       send_idle_pct;
	int       recv_idle_pct;
	bit       stimulus_done;
	bit       drv_valid;
	bit       drv_we;

	always #5 clk = ~clk;

	function automatic bit is_nonterminal(logic [7:0] c);
		return c >= ll1p_pkg::NT_LOW && c <= ll1p_pkg::NT_HIGH;
	endfunction

	function automatic ll1p_pkg::result_t make_result(ll1p_pkg::ev_code_t ev, logic [7:0] nt,
		logic [7:0] la, logic [63:0] rhs, logic [3:0] len);
		ll1p_pkg::result_t r;
		r.event_res = ev;
		r.expanded_symbol = nt;
		r.lookahead_symbol = la;
		r.applied_rhs = rhs;
		r.applied_length = len;
		r.last = 1'b0;
		return r;
	endfunction

	// Advance the parser model by one accepted item and queue what it reports.
	task automatic predict_parse(ll1p_tb_pkg::req_item_t it);
		ll1p_pkg::result_t outs[$];
		logic [7:0]  top;
		logic [7:0]  c;
		logic [63:0] rhs;
		int          len;
		int          idx;
		int          expansions;
		case (it.req_type)
			ll1p_pkg::REQ_LOAD: begin
				if (is_nonterminal(it.entry_nonterminal)) begin
					len = it.rhs_length > 8 ? 8 : it.rhs_length;
					rhs = it.rhs_symbols;
					if (len < 8)
						rhs = rhs & ((64'd1 << (8 * len)) - 64'd1);
					if (len == 1 && rhs == {56'd0, ll1p_pkg::EMPTY_MARK}) begin
						len = 0;
						rhs = 64'd0;
					end
					idx = (it.entry_nonterminal - ll1p_pkg::NT_LOW) * 256 + it.entry_lookahead;
					tbl_valid[idx] = 1'b1;
					tbl_rhs[idx] = rhs;
					tbl_len[idx] = len[3:0];
				end
			end
			ll1p_pkg::REQ_CLEAR: begin
				foreach (tbl_valid[i])
					tbl_valid[i] = 1'b0;
			end
			ll1p_pkg::REQ_BEGIN: begin
				sym_stack[0] = ll1p_pkg::END_MARK;
				sym_stack[1] = {1'b0, start_sym};
				sym_sp = 2;
				parsing = 1'b1;
			end
			default: begin
				if (parsing) begin
					c = it.input_symbol;
					expansions = 0;
					forever begin
						top = sym_sp != 0 ? sym_stack[sym_sp - 1] : ll1p_pkg::END_MARK;
						if (top == ll1p_pkg::END_MARK) begin
							outs.insert(outs.size(), make_result(c == ll1p_pkg::END_MARK ?
								ll1p_pkg::EV_ACCEPTED : ll1p_pkg::EV_REJECTED,
								8'd0, c, 64'd0, 4'd0));
							parsing = 1'b0;
							break;
						end
						if (top == c) begin
							sym_sp--;
							break;
						end
						idx = is_nonterminal(top) ? (top - ll1p_pkg::NT_LOW) * 256 + c : 0;
						if (!is_nonterminal(top) || !tbl_valid[idx] ||
							expansions >= ll1p_pkg::MAX_EXPANSIONS_DEF ||
							sym_sp - 1 + tbl_len[idx] > ll1p_pkg::STACK_DEPTH_DEF) begin
							outs.insert(outs.size(), make_result(ll1p_pkg::EV_REJECTED, 8'd0, c,
								64'd0, 4'd0));
							parsing = 1'b0;
							break;
						end
						len = tbl_len[idx];
						rhs = tbl_rhs[idx];
						sym_sp--;
						for (int i = len; i > 0; i--) begin
							sym_stack[sym_sp] = rhs[8 * (i - 1) +: 8];
							sym_sp++;
						end
						outs.insert(outs.size(), make_result(ll1p_pkg::EV_APPLIED, top, c, rhs,
							len[3:0]));
						expansions++;
					end
					if (outs.size() > 0)
						outs[outs.size() - 1].last = 1'b1;
					foreach (outs[i])
						expected_q.insert(expected_q.size(), outs[i]);
				end
			end
		endcase
	endtask

	// Driver: presents pending items, idling at random; drains and register writes
	// only go ahead once every expected result has come and the block is idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			drv_we = 1'b0;
			drv_valid = req_ch.valid && !req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				predict_parse(pending_q.pop_front().item);
			end
			if (!drv_valid) begin
				if (pending_q.size() > 0 && !(req_ch.valid && req_ch.ready) &&
					pending_q[0].act != ll1p_tb_pkg::ACT_ITEM) begin
					if (expected_q.size() == 0 && req_ch.ready) begin
						if (pending_q[0].act == ll1p_tb_pkg::ACT_START_WR) begin
							drv_we = 1'b1;
							cfg_wdata <= pending_q[0].start_value;
							start_sym = pending_q[0].start_value;
						end
						void'(pending_q.pop_front());
					end
				end else if (pending_q.size() > 0 && pending_q[0].act == ll1p_tb_pkg::ACT_ITEM &&
					$urandom_range(99) >= send_idle_pct) begin
					drv_valid = 1'b1;
					req_ch.req_type <= pending_q[0].item.req_type;
					req_ch.entry_nonterminal <= pending_q[0].item.entry_nonterminal;
					req_ch.entry_lookahead <= pending_q[0].item.entry_lookahead;
					req_ch.rhs_symbols <= pending_q[0].item.rhs_symbols;
					req_ch.rhs_length <= pending_q[0].item.rhs_length;
					req_ch.input_symbol <= pending_q[0].item.input_symbol;
				end
			end
			req_ch.valid <= drv_valid;
			cfg_we <= drv_we;
		end
	end

	// Monitor: compares each result item with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item: ev=%0d nt=%h la=%h", res_ch.event_res,
							res_ch.expanded_symbol, res_ch.lookahead_symbol);
				end else begin
					ll1p_pkg::result_t want;
					ll1p_pkg::result_t got;
					want = expected_q.pop_front();
					got = {res_ch.event_res, res_ch.expanded_symbol, res_ch.lookahead_symbol,
						res_ch.applied_rhs, res_ch.applied_length, res_ch.last};
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result differs: expected %h, got %h", want, got);
					end
				end
			end
			res_ch.ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	function automatic ll1p_tb_pkg::req_item_t blank_item(ll1p_pkg::req_code_t rt);
		ll1p_tb_pkg::req_item_t it;
		it = '0;
		it.req_type = rt;
		return it;
	endfunction

	function automatic ll1p_tb_pkg::req_item_t load_item(logic [7:0] nt, logic [7:0] la,
		logic [63:0] rhs, logic [3:0] len);
		ll1p_tb_pkg::req_item_t it;
		it = blank_item(ll1p_pkg::REQ_LOAD);
		it.entry_nonterminal = nt;
		it.entry_lookahead = la;
		it.rhs_symbols = rhs;
		it.rhs_length = len;
		return it;
	endfunction

	function automatic ll1p_tb_pkg::req_item_t sym_item(logic [7:0] c);
		ll1p_tb_pkg::req_item_t it;
		it = blank_item(ll1p_pkg::REQ_INPUT);
		it.input_symbol = c;
		return it;
	endfunction

	task automatic queue_item(ll1p_tb_pkg::req_item_t it);
		ll1p_tb_pkg::pending_t p;
		p = '0;
		p.act = ll1p_tb_pkg::ACT_ITEM;
		p.item = it;
		pending_q.insert(pending_q.size(), p);
	endtask

	task automatic queue_ctrl(ll1p_tb_pkg::action_t act, logic [6:0] v);
		ll1p_tb_pkg::pending_t p;
		p = '0;
		p.act = act;
		p.start_value = v;
		pending_q.insert(pending_q.size(), p);
	endtask

	// Random nonterminals A..D, terminals a..d, the end mark, '@' or any byte, so that table hits are frequent.
	function automatic logic [7:0] pick_symbol();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return 8'(ll1p_pkg::NT_LOW + $urandom_range(3));
		if (r < 80)
			return 8'("a" + $urandom_range(3));
		if (r < 90)
			return ll1p_pkg::END_MARK;
		if (r < 94)
			return ll1p_pkg::EMPTY_MARK;
		return 8'($urandom_range(255));
	endfunction

	// A small random grammar over A, B, C, D, terminals a..d, then a few strings.
	task automatic queue_random_phase(int items);
		int          sent;
		logic [63:0] rhs;
		int          len;
		sent = 0;
		queue_item(blank_item(ll1p_pkg::REQ_CLEAR));
		for (int k = 0; k < 16; k++) begin
			len = $urandom_range(99) < 10 ? $urandom_range(15) : $urandom_range(3);
			rhs = {$urandom, $urandom};
			for (int b = 0; b < 8; b++)
				if ($urandom_range(9) < 8)
					rhs[8 * b +: 8] = pick_symbol();
			if ($urandom_range(9) == 0) begin
				len = 1;
				rhs[7:0] = ll1p_pkg::EMPTY_MARK;
			end
			queue_item(load_item(8'(ll1p_pkg::NT_LOW + $urandom_range(3)),
				($urandom_range(1) != 0) ? 8'("a" + $urandom_range(3)) : ll1p_pkg::END_MARK,
				rhs, len[3:0]));
			sent++;
		end
		while (sent < items) begin
			queue_item(blank_item(ll1p_pkg::REQ_BEGIN));
			for (int k = $urandom_range(8); k >= 0; k--) begin
				queue_item(sym_item(k == 0 ? ll1p_pkg::END_MARK : pick_symbol()));
				sent++;
			end
			if ($urandom_range(19) == 0) begin
				queue_item(load_item(8'($urandom_range(255)), 8'($urandom_range(255)),
					{$urandom, $urandom}, 4'($urandom_range(15))));
				sent++;
			end
		end
	endtask

	function automatic ll1p_tb_pkg::req_item_t queue_dummy();
		// An item with every input bit high: its type is input symbol, the parse is idle.
		ll1p_tb_pkg::req_item_t it;
		it = '1;
		return it;
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = ll1p_pkg::REQ_LOAD;
		req_ch.entry_nonterminal = '0;
		req_ch.entry_lookahead = '0;
		req_ch.rhs_symbols = '0;
		req_ch.rhs_length = '0;
		req_ch.input_symbol = '0;
		res_ch.ready = 1'b0;
		mismatches = 0;
		stimulus_done = 1'b0;
		start_sym = ll1p_pkg::START_RESET;
		sym_sp = 0;
		parsing = 1'b0;
		send_idle_pct = 28;
		recv_idle_pct = 49;

		// Directed: S -> a S b | empty, field extremes, bad key, clamp, '@' rule.
		queue_item(sym_item(8'hff));
		queue_item(load_item("S", "a", 64'h0000_0000_0062_5361, 4'd3));
		queue_item(load_item("S", "b", 64'h40, 4'd1));
		queue_item(load_item("S", ll1p_pkg::END_MARK, 64'hffff_ffff_ffff_ff40, 4'd1));
		queue_item(load_item(8'd64, 8'd0, 64'hffff_ffff_ffff_ffff, 4'd15));
		queue_item(load_item(8'd91, 8'd255, 64'd0, 4'd0));
		queue_item(load_item("Z", 8'd255, 64'hffff_ffff_ffff_ffff, 4'd15));
		queue_item(load_item("A", 8'd0, 64'h2323_2323_2323_2341, 4'd8));
		queue_item(blank_item(ll1p_pkg::REQ_BEGIN));
		queue_item(sym_item("a"));
		queue_item(blank_item(ll1p_pkg::REQ_BEGIN));
		queue_item(sym_item("a"));
		queue_item(sym_item("b"));
		queue_item(sym_item(ll1p_pkg::END_MARK));
		queue_item(sym_item("a"));
		queue_item(blank_item(ll1p_pkg::REQ_BEGIN));
		queue_item(sym_item("c"));
		queue_item(blank_item(ll1p_pkg::REQ_BEGIN));
		queue_item(sym_item(ll1p_pkg::END_MARK));
		queue_item(queue_dummy());
		// Endless self-expansion: A -> A on 'x' trips the expansion limit.
		queue_item(load_item("A", "x", 64'h41, 4'd1));
		queue_item(load_item("A", "y", 64'h4141_4141_4141_4141, 4'd8));
		queue_ctrl(ll1p_tb_pkg::ACT_DRAIN, 7'd0);
		queue_ctrl(ll1p_tb_pkg::ACT_START_WR, 7'd65);
		queue_item(blank_item(ll1p_pkg::REQ_BEGIN));
		queue_item(sym_item("x"));
		queue_item(blank_item(ll1p_pkg::REQ_BEGIN));
		queue_item(sym_item("y"));
		queue_item(blank_item(ll1p_pkg::REQ_CLEAR));
		queue_item(blank_item(ll1p_pkg::REQ_BEGIN));
		queue_item(sym_item("x"));
		queue_ctrl(ll1p_tb_pkg::ACT_DRAIN, 7'd0);
		queue_ctrl(ll1p_tb_pkg::ACT_START_WR, 7'd90);
		queue_random_phase(50);
		queue_ctrl(ll1p_tb_pkg::ACT_DRAIN, 7'd0);
		queue_ctrl(ll1p_tb_pkg::ACT_START_WR, 7'd83);
		queue_random_phase(120);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_q.size() == 0);
		send_idle_pct = 49;
		recv_idle_pct = 28;
		queue_ctrl(ll1p_tb_pkg::ACT_DRAIN, 7'd0);
		queue_ctrl(ll1p_tb_pkg::ACT_START_WR, 7'd66);
		queue_random_phase(85);
		wait (pending_q.size() == 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_ctrl(ll1p_tb_pkg::ACT_DRAIN, 7'd0);
		queue_ctrl(ll1p_tb_pkg::ACT_START_WR, 7'd65);
		queue_random_phase(75);
		wait (pending_q.size() == 0);
		@(posedge clk);
		wait (expected_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("ll1_table_driven_parser: match");
		else
			$display("ll1_table_driven_parser: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("ll1_table_driven_parser: mismatch");
		$finish;
	end

endmodule

// ----- ll1_table_driven_parser.f -----
rtl/ll1p_pkg.sv
rtl/ll1p_req_if.sv
rtl/ll1p_res_if.sv
rtl/ll1p_ram.sv
rtl/ll1_table_driven_parser.sv
tb/sv/ll1p_tb_if.sv
tb/sv/ll1_table_driven_parser_test.sv
